FILE: rtl/ptss_pkg.sv
package ptss_pkg;

    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_REGISTER = 2'd1;
    localparam logic [1:0] ACT_DELAYED  = 2'd2;
    localparam logic [1:0] ACT_REMOVE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_FND  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_HALTED   = 2'd3;

    localparam logic [31:0] BACKDATE = 32'd4;

    // Widths of the stored name and handle; the ports carry eight bits of each.
    localparam int NAME_WIDTH   = 8;
    localparam int HANDLE_WIDTH = 8;

    // One-hot controller states.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIND  = 7'b0000010,
        S_FCHK  = 7'b0000100,
        S_TICK  = 7'b0001000,
        S_TCHK  = 7'b0010000,
        S_SHIFT = 7'b0100000,
        S_SWR   = 7'b1000000
    } t_state;

endpackage

FILE: rtl/periodic_task_slot_scheduler_top.sv
// Periodic task slot scheduler. Raise start with an item while busy is low; each
// result is on the outputs for one cycle, marked by o_valid, and cannot be stalled.
// Slots live in a single-port memory with a registered read, so every slot visit
// passes through S_FIND or S_TICK and then S_FCHK or S_TCHK. Each fired result
// of a tick is held back until the next firing slot is found or the scan ends, so
// that the final one can carry o_last. Removing a fired one-shot compacts the table,
// moving each later slot down one place, and the slot moved into its place is
// skipped for that tick. A named register searches the table slot by slot for its
// name and appends when none matches; a remove searches the same way and compacts
// the table on a match. The result follows the last busy cycle. Once the table has
// overflowed, every item is answered in the next cycle and busy stays low. No
// clearing pass after reset.
module periodic_task_slot_scheduler_top #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic        i_has_name,
    input  logic [7:0]  i_name_id,
    input  logic [7:0]  i_task_handle,
    input  logic [31:0] i_interval_us,
    input  logic [31:0] i_time_us,
    output logic        o_valid,
    output logic        o_fired,
    output logic [7:0]  o_fired_handle,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import ptss_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef struct packed {
        logic                    named;
        logic [NAME_WIDTH-1:0]   name;
        logic [HANDLE_WIDTH-1:0] handle;
        logic [31:0]             interval;
        logic [31:0]             stamp;
        logic                    once;
    } t_slot;

    // Slot memory, one address per cycle for both the read and the write, registered read.
    t_slot mem [SLOTS];
    t_slot r_rd;

    t_state         r_state,    n_state;
    logic [CW-1:0]  r_used,     n_used;
    logic           r_halted,   n_halted;
    logic [CW-1:0]  r_idx,      n_idx;
    logic [CW-1:0]  r_cnt,      n_cnt;     // compaction position
    logic           r_ret_tick, n_ret_tick;
    logic           r_wr,       n_wr;      // slot write pending
    logic           r_pend,     n_pend;    // fired result held back
    logic [7:0]     r_pend_hdl, n_pend_hdl;
    logic [1:0]     r_act,      n_act;
    logic           r_hn,       n_hn;
    logic [NAME_WIDTH-1:0]   r_name, n_name;
    logic [HANDLE_WIDTH-1:0] r_hdl,  n_hdl;
    logic [31:0]    r_ivl,      n_ivl;
    logic [31:0]    r_now,      n_now;
    logic           r_valid,    n_valid;
    logic           r_fired,    n_fired;
    logic [7:0]     r_fhdl,     n_fhdl;
    logic [1:0]     r_status,   n_status;
    logic           r_last,     n_last;

    logic           mem_we;
    logic [IW-1:0]  mem_addr;
    t_slot          mem_wd;

    logic [CW-1:0]  cnt_p1;
    logic [31:0]    due_time;
    logic           due;
    logic           named_reg;

    assign cnt_p1    = r_cnt + CW'(1);
    assign due_time  = r_rd.stamp + r_rd.interval;
    assign due       = due_time < r_now;
    assign named_reg = (r_act == ACT_REGISTER) && r_hn;
    assign busy      = (r_state != S_IDLE);

    assign o_valid        = r_valid;
    assign o_fired        = r_fired;
    assign o_fired_handle = r_fhdl;
    assign o_status       = r_status;
    assign o_last         = r_last;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_rd <= mem[mem_addr];
    end

    // Memory address and write data.
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_idx[IW-1:0];
        mem_wd   = r_rd;
        case (r_state)
            S_TCHK: begin
                mem_wd.stamp = r_now;
                mem_we       = due && !r_rd.once;
            end
            S_SHIFT: mem_addr = cnt_p1[IW-1:0];
            S_SWR: begin
                mem_addr = r_cnt[IW-1:0];
                mem_we   = 1'b1;
            end
            S_FCHK: begin
                mem_wd.named    = named_reg;
                mem_wd.name     = named_reg ? r_name : '0;
                mem_wd.handle   = r_hdl;
                mem_wd.interval = r_ivl;
                mem_wd.once     = (r_act == ACT_DELAYED);
                mem_wd.stamp    = ((r_act == ACT_DELAYED) && (r_ivl < BACKDATE))
                                  ? (r_now - BACKDATE) : r_now;
                mem_we          = r_wr;
            end
            default: ;
        endcase
    end

    // Controller next state.
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_halted   = r_halted;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_ret_tick = r_ret_tick;
        n_wr       = r_wr;
        n_pend     = r_pend;
        n_pend_hdl = r_pend_hdl;
        n_act      = r_act;
        n_hn       = r_hn;
        n_name     = r_name;
        n_hdl      = r_hdl;
        n_ivl      = r_ivl;
        n_now      = r_now;
        n_valid    = 1'b0;
        n_fired    = r_fired;
        n_fhdl     = r_fhdl;
        n_status   = r_status;
        n_last     = r_last;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act  = i_action;
                    n_hn   = i_has_name;
                    n_name = i_name_id[NAME_WIDTH-1:0];
                    n_hdl  = i_task_handle[HANDLE_WIDTH-1:0];
                    n_ivl  = i_interval_us;
                    n_now  = i_time_us;
                    n_idx  = '0;
                    n_wr   = 1'b0;
                    n_pend = 1'b0;
                    if (r_halted) begin
                        n_valid  = 1'b1;
                        n_fired  = 1'b0;
                        n_fhdl   = '0;
                        n_status = ST_HALTED;
                        n_last   = 1'b1;
                    end else if (i_action == ACT_TICK) begin
                        n_state = S_TICK;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                // Search done, or neither a named register nor a remove.
                if (r_idx >= r_used ||
                    (r_act == ACT_DELAYED) ||
                    (r_act == ACT_REGISTER && !r_hn)) begin
                    if (r_act == ACT_REMOVE) begin
                        n_valid  = 1'b1;
                        n_fired  = 1'b0;
                        n_fhdl   = '0;
                        n_status = ST_NOT_FND;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else if (r_used >= CW'(SLOTS)) begin
                        n_used   = '0;
                        n_halted = 1'b1;
                        n_valid  = 1'b1;
                        n_fired  = 1'b0;
                        n_fhdl   = '0;
                        n_status = ST_FULL;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        // Append at the end of the table.
                        n_idx   = r_used;
                        n_wr    = 1'b1;
                        n_state = S_FCHK;
                    end
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (r_wr) begin
                    // The slot is written in this cycle.
                    if (r_idx == r_used) n_used = r_used + CW'(1);
                    n_valid  = 1'b1;
                    n_fired  = 1'b0;
                    n_fhdl   = '0;
                    n_status = ST_OK;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_rd.named && r_rd.name == r_name) begin
                    if (r_act == ACT_REMOVE) begin
                        n_cnt      = r_idx;
                        n_ret_tick = 1'b0;
                        n_state    = S_SHIFT;
                    end else begin
                        n_wr = 1'b1;
                    end
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_FIND;
                end
            end
            S_TICK: begin
                if (r_idx >= r_used) begin
                    // Release the held result as the final one, or report none.
                    n_valid  = 1'b1;
                    n_fired  = r_pend;
                    n_fhdl   = r_pend ? r_pend_hdl : 8'd0;
                    n_status = ST_OK;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_TCHK;
                end
            end
            S_TCHK: begin
                if (due) begin
                    // A later firing slot exists, so the held one is not final.
                    n_valid    = r_pend;
                    n_fired    = 1'b1;
                    n_fhdl     = r_pend_hdl;
                    n_status   = ST_OK;
                    n_last     = 1'b0;
                    n_pend     = 1'b1;
                    n_pend_hdl = 8'(r_rd.handle);
                    if (r_rd.once) begin
                        n_cnt      = r_idx;
                        n_ret_tick = 1'b1;
                        n_state    = S_SHIFT;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_TICK;
                    end
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_TICK;
                end
            end
            S_SHIFT: begin
                if (cnt_p1 >= r_used) begin
                    n_used = r_used - CW'(1);
                    if (r_ret_tick) begin
                        // Slot moved into place is skipped this tick.
                        n_idx   = r_idx + CW'(1);
                        n_state = S_TICK;
                    end else begin
                        n_valid  = 1'b1;
                        n_fired  = 1'b0;
                        n_fhdl   = '0;
                        n_status = ST_OK;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_SWR;
                end
            end
            S_SWR: begin
                n_cnt   = cnt_p1;
                n_state = S_SHIFT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Controller registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_halted <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_halted <= n_halted;
            r_valid  <= n_valid;
        end
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_ret_tick <= n_ret_tick;
        r_wr       <= n_wr;
        r_pend     <= n_pend;
        r_pend_hdl <= n_pend_hdl;
        r_act      <= n_act;
        r_hn       <= n_hn;
        r_name     <= n_name;
        r_hdl      <= n_hdl;
        r_ivl      <= n_ivl;
        r_now      <= n_now;
        r_fired    <= n_fired;
        r_fhdl     <= n_fhdl;
        r_status   <= n_status;
        r_last     <= n_last;
    end

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(SLOTS)) else $error("used count exceeds table size");
    a_halt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_used == '0) else $error("halted with slots in use");
    a_halt_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_halted) && $past(i_rst_n) |-> r_halted) else $error("halt cleared");
`endif

endmodule

FILE: tb/periodic_task_slot_scheduler_top_tb.sv
module periodic_task_slot_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptss_pkg::*;

    localparam int NUM_SLOTS  = 16;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        bit       fired;
        bit [7:0] handle;
        bit [1:0] status;
        bit       last;
    } sched_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic        i_has_name;
    logic [7:0]  i_name_id;
    logic [7:0]  i_task_handle;
    logic [31:0] i_interval_us;
    logic [31:0] i_time_us;
    logic        o_valid;
    logic        o_fired;
    logic [7:0]  o_fired_handle;
    logic [1:0]  o_status;
    logic        o_last;

    // Shadow copy of the slot table.
    bit        tbl_named    [NUM_SLOTS];
    bit [7:0]  tbl_name     [NUM_SLOTS];
    bit [7:0]  tbl_handle   [NUM_SLOTS];
    bit [31:0] tbl_interval [NUM_SLOTS];
    bit [31:0] tbl_stamp    [NUM_SLOTS];
    bit        tbl_once     [NUM_SLOTS];
    int        tbl_used;
    bit        tbl_halted;

    sched_result_t pending_results[$];
    int            error_count;
    int            stall_cycles;
    int            sender_idle_pct;
    bit [31:0]     clock_now;

    periodic_task_slot_scheduler_top #(
        .SLOTS (NUM_SLOTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_has_name     (i_has_name),
        .i_name_id      (i_name_id),
        .i_task_handle  (i_task_handle),
        .i_interval_us  (i_interval_us),
        .i_time_us      (i_time_us),
        .o_valid        (o_valid),
        .o_fired        (o_fired),
        .o_fired_handle (o_fired_handle),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Queue one expected result.
    task automatic push_result(bit fired, bit [7:0] handle, bit [1:0] status, bit last);
        sched_result_t r;
        r.fired  = fired;
        r.handle = handle;
        r.status = status;
        r.last   = last;
        pending_results.push_back(r);
    endtask

    // Delete one slot and close the gap behind it.
    task automatic drop_entry(int idx);
        for (int j = idx; j + 1 < tbl_used; j++) begin
            tbl_named[j]    = tbl_named[j + 1];
            tbl_name[j]     = tbl_name[j + 1];
            tbl_handle[j]   = tbl_handle[j + 1];
            tbl_interval[j] = tbl_interval[j + 1];
            tbl_stamp[j]    = tbl_stamp[j + 1];
            tbl_once[j]     = tbl_once[j + 1];
        end
        tbl_used--;
    endtask

    function automatic int find_entry(bit [7:0] name);
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_named[i] && tbl_name[i] == name) return i;
        end
        return -1;
    endfunction

    // Update the shadow table for one item and queue the results it causes.
    task automatic schedule_item(bit [1:0] act, bit named, bit [7:0] name, bit [7:0] handle,
                                 bit [31:0] interval, bit [31:0] now);
        int count;
        int pos;
        count = 0;
        if (tbl_halted) begin
            push_result(0, 0, ST_HALTED, 1);
        end else if (act == ACT_TICK) begin
            // A slot moved into a removed one-shot's place waits for the next tick.
            for (int i = 0; i < tbl_used; i++) begin
                if (tbl_stamp[i] + tbl_interval[i] < now) begin
                    tbl_stamp[i] = now;
                    push_result(1, tbl_handle[i], ST_OK, 0);
                    count++;
                    if (tbl_once[i]) drop_entry(i);
                end
            end
            if (count == 0) push_result(0, 0, ST_OK, 1);
            else pending_results[pending_results.size() - 1].last = 1;
        end else if (act == ACT_REMOVE) begin
            pos = find_entry(name);
            if (pos < 0) begin
                push_result(0, 0, ST_NOT_FND, 1);
            end else begin
                drop_entry(pos);
                push_result(0, 0, ST_OK, 1);
            end
        end else begin
            pos = (act == ACT_REGISTER && named) ? find_entry(name) : -1;
            if (pos < 0 && tbl_used >= NUM_SLOTS) begin
                tbl_used   = 0;
                tbl_halted = 1;
                push_result(0, 0, ST_FULL, 1);
            end else begin
                if (pos < 0) begin
                    pos = tbl_used;
                    tbl_used++;
                end
                tbl_handle[pos]   = handle;
                tbl_interval[pos] = interval;
                if (act == ACT_REGISTER) begin
                    tbl_named[pos] = named;
                    tbl_name[pos]  = named ? name : 8'd0;
                    tbl_stamp[pos] = now;
                    tbl_once[pos]  = 0;
                end else begin
                    tbl_named[pos] = 0;
                    tbl_name[pos]  = 0;
                    tbl_stamp[pos] = (interval < BACKDATE) ? now - BACKDATE : now;
                    tbl_once[pos]  = 1;
                end
                push_result(0, 0, ST_OK, 1);
            end
        end
    endtask

    // Present one item, hold it until accepted, then maybe pause.
    task automatic send_item(bit [1:0] act, bit named, bit [7:0] name, bit [7:0] handle,
                             bit [31:0] interval, bit [31:0] now);
        i_action      <= act;
        i_has_name    <= named;
        i_name_id     <= name;
        i_task_handle <= handle;
        i_interval_us <= interval;
        i_time_us     <= now;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        schedule_item(act, named, name, handle, interval, now);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Let the block finish everything in flight.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        sched_result_t exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: fired=%0d handle=%0d status=%0d last=%0d",
                       o_fired, o_fired_handle, o_status, o_last);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_fired !== exp_r.fired) begin
                    $error("fired: expected %0d, got %0d", exp_r.fired, o_fired);
                    error_count++;
                end
                if (o_fired_handle !== exp_r.handle) begin
                    $error("fired_handle: expected %0d, got %0d", exp_r.handle, o_fired_handle);
                    error_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    error_count++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no item and no result moves.
    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Extremes, every action, overwrite, short delays and the skipped slot.
    task automatic test_directed();
        sender_idle_pct = 8;
        send_item(ACT_TICK,     0, 8'd0,   8'd0,   32'd0,          32'd100);
        send_item(ACT_REGISTER, 1, 8'd255, 8'd255, 32'd10,         32'd100);
        send_item(ACT_REGISTER, 0, 8'd255, 8'd1,   32'hFFFF_FFFF,  32'd100);
        send_item(ACT_REGISTER, 1, 8'd255, 8'd7,   32'd5,          32'd101);
        send_item(ACT_REMOVE,   1, 8'd3,   8'd0,   32'd0,          32'd101);
        send_item(ACT_DELAYED,  0, 8'd0,   8'd9,   32'd0,          32'd102);
        send_item(ACT_DELAYED,  1, 8'd255, 8'd10,  32'd3,          32'd102);
        send_item(ACT_DELAYED,  0, 8'd0,   8'd11,  32'd4,          32'd102);
        send_item(ACT_TICK,     0, 8'd0,   8'd0,   32'd0,          32'd103);
        send_item(ACT_TICK,     0, 8'd0,   8'd0,   32'd0,          32'd200);
        send_item(ACT_TICK,     0, 8'd0,   8'd0,   32'd0,          32'd300);
        send_item(ACT_REGISTER, 1, 8'd0,   8'd0,   32'd0,          32'hFFFF_FFFF);
        send_item(ACT_REMOVE,   0, 8'd255, 8'd0,   32'd0,          32'd300);
        send_item(ACT_REMOVE,   1, 8'd255, 8'd0,   32'd0,          32'd300);
        send_item(ACT_DELAYED,  0, 8'd0,   8'd200, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_item(ACT_DELAYED,  0, 8'd0,   8'd201, 32'd1,          32'd0);
        send_item(ACT_TICK,     0, 8'd0,   8'd0,   32'd0,          32'd0);
        send_item(ACT_TICK,     0, 8'd0,   8'd0,   32'd0,          32'hFFFF_FFFF);
        send_item(ACT_REMOVE,   0, 8'd0,   8'd0,   32'd0,          32'd0);
        drain_results();
    endtask

    // Random mix of mostly well-formed traffic with a slowly moving clock.
    task automatic test_random(int count, int idle_pct);
        bit [1:0]  act;
        bit [7:0]  name;
        bit [31:0] interval;
        int        pick;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) act = ACT_TICK;
            else if (pick < 60) act = ACT_REGISTER;
            else if (pick < 80) act = ACT_DELAYED;
            else act = ACT_REMOVE;
            if (act != ACT_TICK && act != ACT_REMOVE && tbl_used >= NUM_SLOTS - 2)
                act = ACT_REMOVE;
            name = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
            if (act == ACT_REMOVE && tbl_used > 0 && $urandom_range(1)
                && tbl_named[$urandom_range(tbl_used - 1)])
                name = tbl_name[0];
            if (act == ACT_REMOVE && tbl_used > 0) begin
                pick = $urandom_range(tbl_used - 1);
                if (tbl_named[pick] && $urandom_range(3) != 0) name = tbl_name[pick];
            end
            interval = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(40));
            if ($urandom_range(15) == 0) clock_now = $urandom;
            else clock_now = clock_now + 32'($urandom_range(30));
            send_item(act, 1'($urandom), name, 8'($urandom), interval, clock_now);
        end
        drain_results();
    endtask

    // Fill the table, overflow it, then check that every action is answered as halted.
    task automatic test_overflow();
        sender_idle_pct = 0;
        while (tbl_used < NUM_SLOTS)
            send_item(ACT_REGISTER, 0, 8'($urandom), 8'($urandom), 32'd50, clock_now);
        send_item(ACT_DELAYED,  0, 8'd0, 8'd5, 32'd1, clock_now);
        send_item(ACT_TICK,     0, 8'd0, 8'd0, 32'd0, clock_now + 32'd1000);
        send_item(ACT_REGISTER, 1, 8'd1, 8'd5, 32'd1, clock_now);
        send_item(ACT_DELAYED,  0, 8'd0, 8'd5, 32'd1, clock_now);
        send_item(ACT_REMOVE,   1, 8'd1, 8'd0, 32'd0, clock_now);
        drain_results();
    endtask

    initial begin
        error_count     = 0;
        stall_cycles    = 0;
        tbl_used        = 0;
        tbl_halted      = 0;
        clock_now       = 32'd1000;
        sender_idle_pct = 0;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_action      <= ACT_TICK;
        i_has_name    <= 1'b0;
        i_name_id     <= 8'd0;
        i_task_handle <= 8'd0;
        i_interval_us <= 32'd0;
        i_time_us     <= 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(44, 8);
        test_random(44, 83);
        test_random(44, 0);
        test_overflow();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
